>>> sv/fsbrc_pkg.sv
// Shared constants, codes and memory entry types of the bitmap reference checker.
package fsbrc_pkg;

    localparam int MAX_INODES  = 128;
    localparam int DATA_BLOCKS = 64;

    localparam int INODE_AW = (MAX_INODES > 1) ? $clog2(MAX_INODES) : 1;
    localparam int BLK_AW   = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
    localparam int CNT_W    = $clog2(MAX_INODES + 1);
    localparam int SPAN_W   = $clog2(DATA_BLOCKS + 1);

    localparam int OP_W   = 3;
    localparam int IDX_W  = 7;
    localparam int WORD_W = 32;
    localparam int FIND_W = 3;
    localparam int CFG_W  = 8;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] DATA_FIRST_RST = 8'd8;
    localparam logic [CFG_W-1:0] DATA_LAST_RST  = 8'd63;

    localparam logic [1:0] REG_REPAIR      = 2'd0;
    localparam logic [1:0] REG_INODE_COUNT = 2'd1;
    localparam logic [1:0] REG_DATA_FIRST  = 2'd2;
    localparam logic [1:0] REG_DATA_LAST   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_INODE   = 3'd0,
        OP_LOAD_DATA    = 3'd1,
        OP_CHECK_INODE  = 3'd2,
        OP_CHECK_DATA   = 3'd3,
        OP_CHECK_REF    = 3'd4,
        OP_CLEAR_OWNERS = 3'd5
    } op_t;

    typedef enum logic [FIND_W-1:0] {
        FIND_OK                   = 3'd0,
        FIND_INODE_MARKED_INVALID = 3'd1,
        FIND_INODE_VALID_UNMARKED = 3'd2,
        FIND_BLOCK_MARKED_UNUSED  = 3'd3,
        FIND_BLOCK_USED_UNMARKED  = 3'd4,
        FIND_BAD_POINTER          = 3'd5,
        FIND_DUPLICATE            = 3'd6
    } finding_t;

    typedef struct packed {
        logic              valid;
        logic              used;
        logic [WORD_W-1:0] ptr;
    } inode_entry_t;

    typedef struct packed {
        logic             data_bit;
        logic [IDX_W-1:0] owner;
    } blk_entry_t;

endpackage

>>> sv/fs_bitmap_reference_checker_core.sv
// Top level of the filesystem bitmap reference checker: control, memories and ports.
//
// The checker holds one inode table (valid flag, inode-bitmap bit and direct block
// pointer per inode) and one block table (data-bitmap bit and first owner per data
// block) in two synchronous memories with registered reads; owned flags for the
// blocks sit in flip-flops that reset and the clear-owners op wipe at once. Items are
// taken one at a time. A load inode item writes its entry, a clear owners item wipes
// the owned flags, a load data bit reads its entry and writes it back, an inode check
// reads the inode and scores it, a reference check reads the inode, then the block at
// the pointer's offset, and a data check walks the inode table's single read port one
// inode per cycle over the counted inodes (inode_count capped at MAX_INODES). Checks
// out of range, loads out of range and unused op codes finish early with no result.
// A result sits in an output register on the master side; the next item waits only
// when its own result would find that register still full. Configuration must be
// written through the APB port only while no item is in flight; the block does not
// enforce this. Reads return the register values. No clearing pass runs after reset.
module fs_bitmap_reference_checker_core
    import fsbrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // op[2:0], index[9:3], links_count[41:10], delete_time[73:42],
    // direct_block[105:74], bit_in[106], zero pad [111:107]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // finding[2:0], item_index[9:3], prior_owner[16:10], bad_block[48:17],
    // bit_after[49], repaired[50], zero pad [55:51]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_PTR   = 5'b00100,
        S_WALK  = 5'b01000,
        S_EXEC  = 5'b10000
    } state_t;

    // Configuration registers
    logic             repair_enable_reg;
    logic [CFG_W-1:0] inode_count_reg;
    logic [CFG_W-1:0] data_first_reg;
    logic [CFG_W-1:0] data_last_reg;
    logic             cfg_we;

    // Control
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic             used_reg, used_next;
    logic             in_range_reg, in_range_next;
    logic [BLK_AW-1:0] off_reg, off_next;

    // Latched item
    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              new_valid_reg;
    logic [WORD_W-1:0] ptr_reg;
    logic              bit_reg;

    // Memories
    inode_entry_t        inode_mem [MAX_INODES];
    inode_entry_t        inode_rdata_reg;
    logic                inode_re, inode_we;
    logic [INODE_AW-1:0] inode_raddr, inode_waddr;
    inode_entry_t        inode_wdata;

    blk_entry_t        blk_mem [DATA_BLOCKS];
    blk_entry_t        blk_rdata_reg;
    logic              blk_re, blk_we;
    logic [BLK_AW-1:0] blk_raddr, blk_waddr;
    blk_entry_t        blk_wdata;

    logic [DATA_BLOCKS-1:0] owner_set_reg;
    logic                   owner_clr;
    logic                   owner_claim;

    // Output register
    logic              out_valid_reg;
    logic [FIND_W-1:0] out_finding_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [IDX_W-1:0]  out_prior_reg;
    logic [WORD_W-1:0] out_bad_reg;
    logic              out_after_reg;
    logic              out_repaired_reg;
    logic              out_load;
    logic              out_free;

    // Derived ranges
    logic [CNT_W-1:0]    counted;
    logic [CFG_W:0]      span_raw;
    logic [SPAN_W-1:0]   span;
    logic [WORD_W-1:0]   first_word;
    logic [WORD_W-1:0]   ptr_diff;
    logic [WORD_W-1:0]   walk_target;
    logic                walk_hit;
    logic                idx_inode_ok, idx_blk_ok, idx_counted, idx_in_span;
    logic [INODE_AW-1:0] idx_inode_addr;
    logic [BLK_AW-1:0]   idx_blk_addr;

    // Result of the check in flight
    finding_t          res_finding;
    logic [IDX_W-1:0]  res_prior;
    logic [WORD_W-1:0] res_bad;
    logic              res_after;
    logic              res_repaired;
    logic              chk_marked;
    logic              chk_truth;
    logic              inode_fix, blk_fix, claim;

    //--------------------------------------------------------------------------
    // Configuration port: writes land on the access cycle, reads are a plain mux
    //--------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repair_enable_reg <= 1'b0;
            inode_count_reg   <= '0;
            data_first_reg    <= DATA_FIRST_RST;
            data_last_reg     <= DATA_LAST_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_REPAIR:      repair_enable_reg <= pwdata[0];
                REG_INODE_COUNT: inode_count_reg   <= pwdata[CFG_W-1:0];
                REG_DATA_FIRST:  data_first_reg    <= pwdata[CFG_W-1:0];
                REG_DATA_LAST:   data_last_reg     <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_REPAIR:      prdata = APB_DW'(repair_enable_reg);
            REG_INODE_COUNT: prdata = APB_DW'(inode_count_reg);
            REG_DATA_FIRST:  prdata = APB_DW'(data_first_reg);
            REG_DATA_LAST:   prdata = APB_DW'(data_last_reg);
            default:         prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------------
    // Counted inodes and data span: the user keeps both fixed while items are in flight; not enforced here
    //--------------------------------------------------------------------------
    assign counted = (32'(inode_count_reg) > 32'(MAX_INODES)) ? CNT_W'(MAX_INODES)
                                                              : CNT_W'(inode_count_reg);
    assign span_raw = {1'b0, data_last_reg} - {1'b0, data_first_reg} + 9'd1;

    always_comb
    begin
        if (data_last_reg < data_first_reg)
            span = '0;
        else if (32'(span_raw) > 32'(DATA_BLOCKS))
            span = SPAN_W'(DATA_BLOCKS);
        else
            span = SPAN_W'(span_raw);
    end

    assign first_word  = WORD_W'(data_first_reg);
    assign ptr_diff    = inode_rdata_reg.ptr - first_word;
    // A data check only runs for an offset inside the span, so a pointer hits the
    // block exactly when it equals first block plus offset.
    assign walk_target = first_word + WORD_W'(idx_reg);
    assign walk_hit    = inode_rdata_reg.valid && (inode_rdata_reg.ptr == walk_target);

    assign idx_inode_ok   = 32'(idx_reg) < 32'(MAX_INODES);
    assign idx_blk_ok     = 32'(idx_reg) < 32'(DATA_BLOCKS);
    assign idx_counted    = 32'(idx_reg) < 32'(counted);
    assign idx_in_span    = 32'(idx_reg) < 32'(span);
    assign idx_inode_addr = INODE_AW'(idx_reg);
    assign idx_blk_addr   = BLK_AW'(idx_reg);

    //--------------------------------------------------------------------------
    // Item capture
    //--------------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg        <= op_t'(s_axis_tdata[2:0]);
            idx_reg       <= s_axis_tdata[9:3];
            new_valid_reg <= (s_axis_tdata[41:10] != '0) && (s_axis_tdata[73:42] == '0);
            ptr_reg       <= s_axis_tdata[105:74];
            bit_reg       <= s_axis_tdata[106];
        end
    end

    //--------------------------------------------------------------------------
    // Check result from the data read back out of the memories
    //--------------------------------------------------------------------------
    always_comb
    begin
        res_finding  = FIND_OK;
        res_prior    = '0;
        res_bad      = '0;
        res_after    = 1'b0;
        res_repaired = 1'b0;
        inode_fix    = 1'b0;
        blk_fix      = 1'b0;
        claim        = 1'b0;
        chk_marked   = 1'b0;
        chk_truth    = 1'b0;

        case (op_reg)
            OP_CHECK_INODE:
            begin
                chk_marked = inode_rdata_reg.used;
                chk_truth  = inode_rdata_reg.valid;
                res_after  = chk_marked;
                if (chk_marked && !chk_truth)
                    res_finding = FIND_INODE_MARKED_INVALID;
                else if (!chk_marked && chk_truth)
                    res_finding = FIND_INODE_VALID_UNMARKED;
                if (res_finding != FIND_OK && repair_enable_reg)
                begin
                    res_after    = chk_truth;
                    res_repaired = 1'b1;
                    inode_fix    = 1'b1;
                end
            end
            OP_CHECK_DATA:
            begin
                chk_marked = blk_rdata_reg.data_bit;
                chk_truth  = used_reg;
                res_after  = chk_marked;
                if (chk_marked && !chk_truth)
                    res_finding = FIND_BLOCK_MARKED_UNUSED;
                else if (!chk_marked && chk_truth)
                    res_finding = FIND_BLOCK_USED_UNMARKED;
                if (res_finding != FIND_OK && repair_enable_reg)
                begin
                    res_after    = chk_truth;
                    res_repaired = 1'b1;
                    blk_fix      = 1'b1;
                end
            end
            OP_CHECK_REF:
            begin
                // An invalid inode reports ok and claims nothing
                if (inode_rdata_reg.valid)
                begin
                    if (!in_range_reg)
                    begin
                        res_finding = FIND_BAD_POINTER;
                        res_bad     = inode_rdata_reg.ptr;
                    end
                    else if (owner_set_reg[off_reg])
                    begin
                        res_finding = FIND_DUPLICATE;
                        res_bad     = inode_rdata_reg.ptr;
                        res_prior   = blk_rdata_reg.owner;
                    end
                    else
                    begin
                        claim = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    //--------------------------------------------------------------------------
    // Sequencer: issue reads, walk the inode table, write back
    //--------------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        used_next     = used_reg;
        in_range_next = in_range_reg;
        off_next      = off_reg;
        inode_re      = 1'b0;
        inode_raddr   = idx_inode_addr;
        inode_we      = 1'b0;
        inode_waddr   = idx_inode_addr;
        inode_wdata   = '{valid: new_valid_reg, used: bit_reg, ptr: ptr_reg};
        blk_re        = 1'b0;
        blk_raddr     = idx_blk_addr;
        blk_we        = 1'b0;
        blk_waddr     = idx_blk_addr;
        blk_wdata     = '{data_bit: bit_reg, owner: blk_rdata_reg.owner};
        owner_clr     = 1'b0;
        owner_claim   = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_LOAD_INODE:
                    begin
                        inode_we = idx_inode_ok;
                    end
                    OP_LOAD_DATA:
                    begin
                        // Read the entry first to keep its owner field
                        if (idx_blk_ok)
                        begin
                            blk_re     = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    OP_CHECK_INODE:
                    begin
                        if (idx_counted)
                        begin
                            inode_re   = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    OP_CHECK_DATA:
                    begin
                        if (idx_in_span)
                        begin
                            blk_re     = 1'b1;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            used_next  = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                    OP_CHECK_REF:
                    begin
                        if (idx_counted)
                        begin
                            inode_re   = 1'b1;
                            state_next = S_PTR;
                        end
                    end
                    OP_CLEAR_OWNERS:
                    begin
                        owner_clr = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_PTR:
            begin
                // Range-check the pointer and fetch its block entry
                in_range_next = (inode_rdata_reg.ptr >= first_word)
                             && (ptr_diff < WORD_W'(span));
                off_next      = BLK_AW'(ptr_diff);
                blk_re        = 1'b1;
                blk_raddr     = BLK_AW'(ptr_diff);
                state_next    = S_EXEC;
            end
            S_WALK:
            begin
                // One inode read per cycle; its data is scored the cycle after
                used_next = used_reg | (pend_reg & walk_hit);
                if (cnt_reg != counted)
                begin
                    inode_re    = 1'b1;
                    inode_raddr = INODE_AW'(cnt_reg);
                    cnt_next    = cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_LOAD_DATA)
                begin
                    blk_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load    = 1'b1;
                    state_next  = S_IDLE;
                    inode_we    = inode_fix;
                    inode_wdata = '{valid: inode_rdata_reg.valid,
                                    used:  inode_rdata_reg.valid,
                                    ptr:   inode_rdata_reg.ptr};
                    blk_we      = blk_fix || claim;
                    owner_claim = claim;
                    if (claim)
                    begin
                        blk_waddr = off_reg;
                        blk_wdata = '{data_bit: blk_rdata_reg.data_bit, owner: idx_reg};
                    end
                    else
                    begin
                        blk_wdata = '{data_bit: used_reg, owner: blk_rdata_reg.owner};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg     <= used_next;
        in_range_reg <= in_range_next;
        off_reg      <= off_next;
    end

    //--------------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    //--------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (inode_we)
            inode_mem[inode_waddr] <= inode_wdata;
        if (inode_re)
            inode_rdata_reg <= inode_mem[inode_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
            blk_mem[blk_waddr] <= blk_wdata;
        if (blk_re)
            blk_rdata_reg <= blk_mem[blk_raddr];
    end

    // Owned flags: wiped together, set one at a time by a claim
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            owner_set_reg <= '0;
        else if (owner_clr)
            owner_set_reg <= '0;
        else if (owner_claim)
            owner_set_reg[off_reg] <= 1'b1;
    end

    //--------------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_finding_reg  <= res_finding;
            out_index_reg    <= idx_reg;
            out_prior_reg    <= res_prior;
            out_bad_reg      <= res_bad;
            out_after_reg    <= res_after;
            out_repaired_reg <= res_repaired;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_repaired_reg, out_after_reg, out_bad_reg,
                            out_prior_reg, out_index_reg, out_finding_reg};

`ifndef NO_ASSERTIONS
    // Only check ops produce results
    a_result_op: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (op_reg == OP_CHECK_INODE || op_reg == OP_CHECK_DATA
                      || op_reg == OP_CHECK_REF))
        else $error("result loaded for an op that gives none");

    // The walk never reads past the counted inodes
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cnt_reg <= counted))
        else $error("inode walk ran past counted inodes");

    // Write-back never collides with a read of the same memory
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(blk_we && blk_re) && !(inode_we && inode_re))
        else $error("memory read and write in the same cycle");

    // A claim only lands on an unowned block
    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        owner_claim |-> !owner_set_reg[off_reg])
        else $error("claim on a block that already has an owner");

    // Clear owners leaves every block unowned
    a_clear_owners: assert property (@(posedge clk) disable iff (!rst_n)
        owner_clr |=> (owner_set_reg == '0))
        else $error("owned flags survived a clear");
`endif

endmodule

>>> tb/fsbrc_finding_check.sv
`timescale 1ns / 1ps
// Checker that tracks bitmap checker items and compares its findings with the block's results.
module fsbrc_finding_check
    import fsbrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // op[2:0], index[9:3], links_count[41:10], delete_time[73:42],
    // direct_block[105:74], bit_in[106], zero pad [111:107]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // finding[2:0], item_index[9:3], prior_owner[16:10], bad_block[48:17],
    // bit_after[49], repaired[50], zero pad [55:51]
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    input  logic                 pready,
    output int unsigned          fail_count,
    output int unsigned          pending_count
);

    typedef struct packed {
        finding_t          finding;
        logic [IDX_W-1:0]  item_index;
        logic [IDX_W-1:0]  prior_owner;
        logic [WORD_W-1:0] bad_block;
        logic              bit_after;
        logic              repaired;
    } finding_rec_t;

    // shadow of the block's tables
    logic              inode_ok       [MAX_INODES];
    logic              inode_mark     [MAX_INODES];
    logic [WORD_W-1:0] inode_ptr      [MAX_INODES];
    logic              block_mark     [DATA_BLOCKS];
    logic              block_owned    [DATA_BLOCKS];
    logic [IDX_W-1:0]  block_owner_id [DATA_BLOCKS];

    logic              repair_on;
    logic [CFG_W-1:0]  inode_limit;
    logic [CFG_W-1:0]  first_blk;
    logic [CFG_W-1:0]  last_blk;

    finding_rec_t findings_due[$];

    initial fail_count = 0;

    function automatic int unsigned counted_inodes();
        return (inode_limit > MAX_INODES) ? MAX_INODES : inode_limit;
    endfunction

    function automatic int unsigned span_bits();
        int unsigned s;
        if (last_blk < first_blk)
            return 0;
        s = last_blk - first_blk + 1;
        return (s > DATA_BLOCKS) ? DATA_BLOCKS : s;
    endfunction

    function automatic bit block_offset(input logic [WORD_W-1:0] p, output int unsigned off);
        logic [WORD_W-1:0] d;
        if (p < first_blk)
            return 0;
        d = p - first_blk;
        if (d >= span_bits())
            return 0;
        off = d;
        return 1;
    endfunction

    // Apply one item to the shadow state; return 1 with the finding when it yields a result.
    function automatic bit audit_item(input logic [S_TDATA_W-1:0] word,
                                      output finding_rec_t rec);
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] links;
        logic [WORD_W-1:0] dtime;
        logic [WORD_W-1:0] ptr;
        logic              bit_in;
        int unsigned       off;
        int unsigned       n;
        bit                used;
        op     = word[2:0];
        idx    = word[9:3];
        links  = word[41:10];
        dtime  = word[73:42];
        ptr    = word[105:74];
        bit_in = word[106];
        off    = 0;
        rec    = '0;
        rec.item_index = idx;
        case (op)
            OP_LOAD_INODE:
            begin
                if (idx < MAX_INODES)
                begin
                    inode_ok[idx]   = (links != 0) && (dtime == 0);
                    inode_mark[idx] = bit_in;
                    inode_ptr[idx]  = ptr;
                end
                return 0;
            end
            OP_LOAD_DATA:
            begin
                if (idx < DATA_BLOCKS)
                    block_mark[idx] = bit_in;
                return 0;
            end
            OP_CHECK_INODE:
            begin
                if (idx >= counted_inodes())
                    return 0;
                rec.bit_after = inode_mark[idx];
                if (inode_mark[idx] && !inode_ok[idx])
                    rec.finding = FIND_INODE_MARKED_INVALID;
                else if (!inode_mark[idx] && inode_ok[idx])
                    rec.finding = FIND_INODE_VALID_UNMARKED;
                if (rec.finding != FIND_OK && repair_on)
                begin
                    rec.bit_after   = inode_ok[idx];
                    inode_mark[idx] = inode_ok[idx];
                    rec.repaired    = 1'b1;
                end
            end
            OP_CHECK_DATA:
            begin
                if (idx >= span_bits())
                    return 0;
                used = 0;
                n = counted_inodes();
                for (int i = 0; i < n; i++)
                    if (inode_ok[i] && block_offset(inode_ptr[i], off) && off == idx)
                        used = 1;
                rec.bit_after = block_mark[idx];
                if (block_mark[idx] && !used)
                    rec.finding = FIND_BLOCK_MARKED_UNUSED;
                else if (!block_mark[idx] && used)
                    rec.finding = FIND_BLOCK_USED_UNMARKED;
                if (rec.finding != FIND_OK && repair_on)
                begin
                    rec.bit_after   = used;
                    block_mark[idx] = used;
                    rec.repaired    = 1'b1;
                end
            end
            OP_CHECK_REF:
            begin
                if (idx >= counted_inodes())
                    return 0;
                if (inode_ok[idx])
                begin
                    if (!block_offset(inode_ptr[idx], off))
                    begin
                        rec.finding   = FIND_BAD_POINTER;
                        rec.bad_block = inode_ptr[idx];
                    end
                    else if (block_owned[off])
                    begin
                        rec.finding     = FIND_DUPLICATE;
                        rec.bad_block   = inode_ptr[idx];
                        rec.prior_owner = block_owner_id[off];
                    end
                    else
                    begin
                        block_owned[off]    = 1'b1;
                        block_owner_id[off] = idx;
                    end
                end
            end
            OP_CLEAR_OWNERS:
            begin
                for (int i = 0; i < DATA_BLOCKS; i++)
                    block_owned[i] = 1'b0;
                return 0;
            end
            default:
                return 0;
        endcase
        return 1;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        finding_rec_t want;
        finding_rec_t fresh;
        if (!rst_n)
        begin
            repair_on   = 1'b0;
            inode_limit = '0;
            first_blk   = DATA_FIRST_RST;
            last_blk    = DATA_LAST_RST;
            for (int i = 0; i < DATA_BLOCKS; i++)
                block_owned[i] = 1'b0;
            findings_due.delete();
            pending_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_REPAIR:      repair_on   = pwdata[0];
                    REG_INODE_COUNT: inode_limit = pwdata[CFG_W-1:0];
                    REG_DATA_FIRST:  first_blk   = pwdata[CFG_W-1:0];
                    REG_DATA_LAST:   last_blk    = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            // results first: a result at this edge always belongs to an older item
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (findings_due.size() == 0)
                begin
                    $error("result with no item waiting: finding %0d index %0d",
                           m_axis_tdata[2:0], m_axis_tdata[9:3]);
                    fail_count++;
                end
                else
                begin
                    want = findings_due.pop_front();
                    check_field("finding", want.finding, m_axis_tdata[2:0]);
                    check_field("item_index", want.item_index, m_axis_tdata[9:3]);
                    check_field("prior_owner", want.prior_owner, m_axis_tdata[16:10]);
                    check_field("bad_block", want.bad_block, m_axis_tdata[48:17]);
                    check_field("bit_after", want.bit_after, m_axis_tdata[49]);
                    check_field("repaired", want.repaired, m_axis_tdata[50]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                if (audit_item(s_axis_tdata, fresh))
                    findings_due.push_back(fresh);
            pending_count <= findings_due.size();
        end
    end

endmodule

>>> tb/fs_bitmap_reference_checker_core_tb.sv
`timescale 1ns / 1ps
// Top of the bitmap reference checker bench: clock, reset, stimulus, flow control and verdict.
module fs_bitmap_reference_checker_core_tb;
    import fsbrc_pkg::*;

    // op codes the block leaves unused; they must be swallowed without a result
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // a data check walks every counted inode, so allow a full walk plus margin
    localparam int DRAIN_CYCLES = MAX_INODES + 12;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // op[2:0], index[9:3], links_count[41:10], delete_time[73:42],
    // direct_block[105:74], bit_in[106], zero pad [111:107]
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // finding[2:0], item_index[9:3], prior_owner[16:10], bad_block[48:17],
    // bit_after[49], repaired[50], zero pad [55:51]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [APB_AW-1:0]    paddr         = '0;
    logic [APB_DW-1:0]    pwdata        = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int unsigned mismatch_total;
    int unsigned items_waiting;

    // settings last written, kept only to aim the stimulus at the live ranges
    int unsigned cur_count = 0;
    int unsigned cur_first = DATA_FIRST_RST;
    int unsigned cur_last  = DATA_LAST_RST;

    int burst_left = 0;
    int ready_hold = 0;

    fs_bitmap_reference_checker_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fsbrc_finding_check u_finding_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (mismatch_total),
        .pending_count (items_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: far above the slowest legal run (every item a full inode walk,
    // every result held by the longest stall, every item behind the longest gap).
    initial
    begin
        #40_000_000;
        $display("FAIL fs_bitmap_reference_checker_core");
        $finish;
    end

    // Result side: mix long always-ready stretches, long stalls and short
    // random toggling so stalls land on every phase of the block's work.
    always @(posedge clk)
    begin : result_flow
        int unsigned pick;
        if (ready_hold > 0)
            ready_hold--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                m_axis_tready <= 1'b1;
                ready_hold = 120;
            end
            else if (pick < 20)
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(5, 20);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
                ready_hold = $urandom_range(0, 3);
            end
        end
    end

    function automatic int unsigned counted_now();
        return (cur_count > MAX_INODES) ? MAX_INODES : cur_count;
    endfunction

    function automatic int unsigned span_now();
        int unsigned s;
        if (cur_last < cur_first)
            return 0;
        s = cur_last - cur_first + 1;
        return (s > DATA_BLOCKS) ? DATA_BLOCKS : s;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(input logic [OP_W-1:0] op,
                                                       input logic [IDX_W-1:0] idx,
                                                       input logic [WORD_W-1:0] links,
                                                       input logic [WORD_W-1:0] dtime,
                                                       input logic [WORD_W-1:0] ptr,
                                                       input logic bit_in);
        return {{(S_TDATA_W-107){1'b0}}, bit_in, ptr, dtime, links, idx, op};
    endfunction

    // Offer one item and hold it until accepted. Valid stays high on return so a
    // burst can run back to back; gaps between bursts drop it first.
    task automatic push_item(input logic [S_TDATA_W-1:0] word);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(15, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Build an item with inode-like content: mostly live inodes pointing into the
    // data range, with dead inodes, range edges and wild pointers mixed in.
    task automatic push_random(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] links;
        logic [WORD_W-1:0] dtime;
        logic [WORD_W-1:0] ptr;
        int unsigned       pick;
        int unsigned       sp;
        sp   = span_now();
        pick = $urandom_range(0, 99);
        if (pick < 10)
            links = '0;
        else if (pick < 20)
            links = '1;
        else if (pick < 30)
            links = $urandom;
        else
            links = $urandom_range(1, 3);
        pick = $urandom_range(0, 99);
        if (pick < 75)
            dtime = '0;
        else if (pick < 85)
            dtime = '1;
        else
            dtime = $urandom;
        pick = $urandom_range(0, 99);
        if (sp > 0 && pick < 60)
            ptr = cur_first + $urandom_range(0, sp - 1);
        else if (pick < 70)
            ptr = cur_first + sp;
        else if (pick < 75)
            ptr = cur_first - 1;
        else if (pick < 80)
            ptr = '0;
        else if (pick < 85)
            ptr = '1;
        else
            ptr = $urandom;
        push_item(pack_item(op, idx, links, dtime, ptr, $urandom_range(0, 1)));
    endtask

    // Drop valid, wait for every outstanding result, then give an item that
    // yields nothing time to finish before the block is touched again.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (items_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase, then psel drops and the bus idles before return so
    // back-to-back writes never lower and raise psel in the same step.
    task automatic apb_write(input logic [1:0] reg_id, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all registers while idle, then run a stretch of random traffic
    // under that setting.
    task automatic audit_phase(input int unsigned repair, input int unsigned count,
                               input int unsigned first, input int unsigned last,
                               input int n_items);
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        int unsigned      pick;
        settle();
        apb_write(REG_REPAIR, repair);
        apb_write(REG_INODE_COUNT, count);
        apb_write(REG_DATA_FIRST, first);
        apb_write(REG_DATA_LAST, last);
        cur_count = count;
        cur_first = first;
        cur_last  = last;
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                op = OP_LOAD_INODE;
            else if (pick < 40)
                op = OP_LOAD_DATA;
            else if (pick < 55)
                op = OP_CHECK_INODE;
            else if (pick < 67)
                op = OP_CHECK_DATA;
            else if (pick < 93)
                op = OP_CHECK_REF;
            else if (pick < 96)
                op = OP_CLEAR_OWNERS;
            else
                op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            // aim most indexes at the live inodes or the live bitmap span
            pick = $urandom_range(0, 99);
            if (op == OP_LOAD_DATA || op == OP_CHECK_DATA)
                idx = (span_now() > 0 && pick < 85) ? $urandom_range(0, span_now() - 1)
                                                    : $urandom_range(0, 127);
            else
                idx = (counted_now() > 0 && pick < 85) ? $urandom_range(0, counted_now() - 1)
                                                       : $urandom_range(0, 127);
            push_random(op, idx);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every inode and every data bitmap bit first so no check ever
        // reads a table entry that was never written.
        for (int i = 0; i < MAX_INODES; i++)
            push_random(OP_LOAD_INODE, i);
        for (int i = 0; i < DATA_BLOCKS; i++)
            push_random(OP_LOAD_DATA, i);

        // Directed pass: full inode count, data blocks 8..71, report only.
        audit_phase(0, 128, 8, 71, 0);
        push_item(pack_item(OP_LOAD_INODE, 0, 1, 0, 8, 1));            // live, first block
        push_item(pack_item(OP_LOAD_INODE, 1, 0, 0, 0, 1));            // dead but marked
        push_item(pack_item(OP_LOAD_INODE, 2, '1, 0, 71, 0));          // live, last block
        push_item(pack_item(OP_LOAD_INODE, 3, 5, '1, '1, 0));          // deleted
        push_item(pack_item(OP_LOAD_INODE, 4, 2, 0, 8, 1));            // shares inode 0's block
        push_item(pack_item(OP_LOAD_INODE, 5, 1, 0, '1, 1));           // wild pointer
        push_item(pack_item(OP_LOAD_INODE, 6, 1, 0, 7, 1));            // just below the range
        push_item(pack_item(OP_CHECK_INODE, 0, 0, 0, 0, 0));
        push_item(pack_item(OP_CHECK_INODE, 1, 0, 0, 0, 0));
        push_item(pack_item(OP_CHECK_INODE, 2, 0, 0, 0, 0));
        push_item(pack_item(OP_CHECK_REF, 0, 0, 0, 0, 0));             // first claim
        push_item(pack_item(OP_CHECK_REF, 0, 0, 0, 0, 0));             // same inode again
        push_item(pack_item(OP_CHECK_REF, 4, 0, 0, 0, 0));             // duplicate of inode 0
        push_item(pack_item(OP_CHECK_REF, 5, 0, 0, 0, 0));             // bad pointer
        push_item(pack_item(OP_CHECK_REF, 6, 0, 0, 0, 0));             // one below the range
        push_item(pack_item(OP_CHECK_REF, 3, 0, 0, 0, 0));             // dead inode: no claim
        push_item(pack_item(OP_CLEAR_OWNERS, 0, 0, 0, 0, 0));
        push_item(pack_item(OP_CHECK_REF, 4, 0, 0, 0, 0));             // claim after the wipe
        push_item(pack_item(OP_LOAD_DATA, 0, 0, 0, 0, 0));
        push_item(pack_item(OP_LOAD_DATA, 63, 0, 0, 0, 1));
        push_item(pack_item(OP_LOAD_DATA, 100, 0, 0, 0, 1));           // past the bitmap: dropped
        push_item(pack_item(OP_CHECK_DATA, 0, 0, 0, 0, 0));
        push_item(pack_item(OP_CHECK_DATA, 63, 0, 0, 0, 0));
        push_item(pack_item(OP_CHECK_DATA, 64, 0, 0, 0, 0));           // outside the span
        push_item(pack_item(OP_SPARE_LO, 7'h7F, '1, '1, '1, 1'b1));
        push_item(pack_item(OP_SPARE_HI, 7'h7F, '1, '1, '1, 1'b1));

        // Random phases across the register extremes: count zero, count above
        // the table size, empty and one-block spans, ranges at both ends.
        audit_phase(0, 128, 8, 71, 240);
        audit_phase(1, 128, 8, 71, 240);
        audit_phase(1, 0, 8, 63, 120);
        audit_phase(0, 255, 0, 255, 240);
        audit_phase(1, 1, 255, 255, 200);
        audit_phase(0, 40, 100, 50, 120);
        audit_phase(1, $urandom_range(1, 128), $urandom_range(0, 255),
                    $urandom_range(0, 255), 240);
        audit_phase(0, 128, 0, 63, 240);

        // Hold until every result is back and the last item has retired.
        settle();
        if (mismatch_total == 0 && items_waiting == 0)
            $display("PASS fs_bitmap_reference_checker_core");
        else
            $display("FAIL fs_bitmap_reference_checker_core");
        $finish;
    end

endmodule

>>> fs_bitmap_reference_checker_core.f
sv/fsbrc_pkg.sv
sv/fs_bitmap_reference_checker_core.sv
tb/fsbrc_finding_check.sv
tb/fs_bitmap_reference_checker_core_tb.sv
